// File: hdl/fplc_pkg.sv
`timescale 1ns / 1ps

package fplc_pkg;

  // command codes
  localparam logic [2:0] FN_NOP    = 3'd0;
  localparam logic [2:0] FN_WRITE  = 3'd1;
  localparam logic [2:0] FN_CHECK  = 3'd2;
  localparam logic [2:0] FN_PROG   = 3'd3;
  localparam logic [2:0] FN_JUMP   = 3'd4;
  localparam logic [2:0] FN_STAGE0 = 3'd5;

  // status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_HELLO      = 4'd1;
  localparam logic [3:0] ST_STAGE0     = 4'd2;
  localparam logic [3:0] ST_WRONG_SIZE = 4'd3;
  localparam logic [3:0] ST_OOB        = 4'd4;
  localparam logic [3:0] ST_TOO_LOW    = 4'd5;
  localparam logic [3:0] ST_TOO_HIGH   = 4'd6;
  localparam logic [3:0] ST_UNALIGNED  = 4'd7;
  localparam logic [3:0] ST_CRC_BAD    = 4'd8;
  localparam logic [3:0] ST_UNKNOWN    = 4'd9;

  // configuration register indexes
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  localparam logic [31:0] LOW_RESET  = 32'h0001_0000;
  localparam logic [31:0] HIGH_RESET = 32'h0003_E000;

  // packet lengths including the opcode byte
  localparam logic [6:0] LEN_CHECK = 7'd3;
  localparam logic [6:0] LEN_PROG  = 7'(1 + 4 + 2);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_WRITE  = 6'b001000,
    S_CRC    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  // one byte of reflected CRC-16, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/fplc_in_if.sv
`timescale 1ns / 1ps

interface fplc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [6:0]  packet_len;
  logic [7:0]  chunk_offset;
  logic [63:0] chunk_data;
  logic [31:0] target_address;
  logic [15:0] claimed_crc;

  modport source (
    output valid, func, packet_len, chunk_offset, chunk_data, target_address, claimed_crc,
    input  ready
  );

  modport sink (
    input  valid, func, packet_len, chunk_offset, chunk_data, target_address, claimed_crc,
    output ready
  );
endinterface

// File: hdl/fplc_out_if.sv
`timescale 1ns / 1ps

interface fplc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] computed_crc;
  logic        program_request;
  logic [31:0] program_address;
  logic        start_application;

  modport source (
    output valid, status, computed_crc, program_request, program_address, start_application,
    input  ready
  );

  modport sink (
    input  valid, status, computed_crc, program_request, program_address, start_application,
    output ready
  );
endinterface

// File: hdl/flash_page_loader_crc_check_top.sv
`timescale 1ns / 1ps

// Bootloader command engine with a PAGE_BYTES page buffer and CRC-16 check.
// in_ch takes one decoded command per item (valid/ready); out_ch gives one
// result item per command: status, buffer CRC and program/start strobes.
// cfg_we/cfg_index/cfg_wdata write the low and high program address limits.
// The buffer is a single-port synchronous RAM, one byte per cycle.
// PAGE_BYTES must be a power of two: page alignment is a mask of the low
// address bits, checked in the decode cycle with the address limits.
// Nop, jump, stage0 and refused commands go from decode straight to the
// result; a chunk write makes one RAM write per byte, and a buffer check or
// page program makes one RAM read per byte of the page.
// After reset a clearing pass zeroes the buffer; in_ch is not ready during
// it, configuration writes are taken throughout.
// A result waits in the output register while the receiver stalls; the next
// command is accepted and worked meanwhile, and its result is held until the
// output register is free.
module flash_page_loader_crc_check_top #(
  parameter int PAGE_BYTES  = 256,
  parameter int CHUNK_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  fplc_in_if.sink     in_ch,
  fplc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW    = $clog2(PAGE_BYTES);
  localparam int SUM_W = $clog2(PAGE_BYTES + 264) + 1;
  localparam int CNT_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam logic [AW-1:0]    PTR_LAST = AW'(PAGE_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNK_BYTES - 1);
  localparam logic [6:0]       LEN_WRITE = 7'(2 + CHUNK_BYTES);

  fplc_pkg::state_t state_r, dec_state;

  logic [7:0]       mem [PAGE_BYTES];
  logic [7:0]       rd_data_r;
  logic             mem_we, rd_en;
  logic [7:0]       mem_wd;

  logic [AW-1:0]    ptr_r;
  logic [CNT_W-1:0] wcnt_r;
  logic             crc_iss_r, rd_vld_r, rd_last_r;
  logic             out_valid_r;
  logic [31:0]      low_r, high_r;

  logic [2:0]       func_r;
  logic [6:0]       len_r;
  logic [7:0]       off_r;
  logic [63:0]      data_r;
  logic [31:0]      addr_r;
  logic [15:0]      exp_r;

  logic [15:0]      crc_r, crc_upd;

  logic [3:0]       res_status_r, dec_status;
  logic [15:0]      res_crc_r;
  logic             res_prog_r, res_start_r, dec_start;
  logic [31:0]      res_paddr_r;

  logic [3:0]       out_status_r;
  logic [15:0]      out_crc_r;
  logic             out_prog_r, out_start_r;
  logic [31:0]      out_paddr_r;

  logic [SUM_W-1:0] off_sum;
  logic             oob, in_take, out_free;

  assign in_ch.ready = (state_r == fplc_pkg::S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.computed_crc      = out_crc_r;
  assign out_ch.program_request   = out_prog_r;
  assign out_ch.program_address   = out_paddr_r;
  assign out_ch.start_application = out_start_r;

  assign off_sum = SUM_W'(off_r) + SUM_W'(CHUNK_BYTES);
  assign oob     = off_sum > SUM_W'(PAGE_BYTES);

  assign mem_we = (state_r == fplc_pkg::S_CLEAR) || (state_r == fplc_pkg::S_WRITE);
  assign mem_wd = (state_r == fplc_pkg::S_WRITE) ? data_r[7:0] : 8'h00;
  assign rd_en  = (state_r == fplc_pkg::S_CRC) && crc_iss_r;

  assign crc_upd = fplc_pkg::crc16_byte(crc_r, rd_data_r);

  always_comb begin
    dec_status = fplc_pkg::ST_OK;
    dec_state  = fplc_pkg::S_FIN;
    dec_start  = 1'b0;
    if (len_r == 7'd0) begin
      dec_status = fplc_pkg::ST_HELLO;
    end else begin
      unique case (func_r)
        fplc_pkg::FN_NOP: begin
          dec_status = fplc_pkg::ST_STAGE0;
        end
        fplc_pkg::FN_WRITE: begin
          if (len_r != LEN_WRITE) dec_status = fplc_pkg::ST_WRONG_SIZE;
          else if (oob)           dec_status = fplc_pkg::ST_OOB;
          else                    dec_state  = fplc_pkg::S_WRITE;
        end
        fplc_pkg::FN_CHECK: begin
          if (len_r != fplc_pkg::LEN_CHECK) dec_status = fplc_pkg::ST_WRONG_SIZE;
          else                              dec_state  = fplc_pkg::S_CRC;
        end
        fplc_pkg::FN_PROG: begin
          if (len_r != fplc_pkg::LEN_PROG)  dec_status = fplc_pkg::ST_WRONG_SIZE;
          else if (addr_r < low_r)          dec_status = fplc_pkg::ST_TOO_LOW;
          else if (addr_r >= high_r)        dec_status = fplc_pkg::ST_TOO_HIGH;
          else if (addr_r[AW-1:0] != '0)    dec_status = fplc_pkg::ST_UNALIGNED;
          else                              dec_state  = fplc_pkg::S_CRC;
        end
        fplc_pkg::FN_JUMP: begin
          dec_start = 1'b1;
        end
        fplc_pkg::FN_STAGE0: begin
          dec_status = fplc_pkg::ST_OK;
        end
        default: begin
          dec_status = fplc_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

  // page buffer
  always_ff @(posedge clk) begin
    if (mem_we) mem[ptr_r] <= mem_wd;
    if (rd_en)  rd_data_r  <= mem[ptr_r];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fplc_pkg::S_CLEAR;
      ptr_r       <= '0;
      wcnt_r      <= '0;
      crc_iss_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
      low_r       <= fplc_pkg::LOW_RESET;
      high_r      <= fplc_pkg::HIGH_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fplc_pkg::REG_LOW:  low_r  <= cfg_wdata;
          fplc_pkg::REG_HIGH: high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == fplc_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r  <= rd_en;
      rd_last_r <= rd_en && (ptr_r == PTR_LAST);

      unique case (state_r)
        fplc_pkg::S_CLEAR: begin
          if (ptr_r == PTR_LAST) begin
            ptr_r   <= '0;
            state_r <= fplc_pkg::S_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        fplc_pkg::S_IDLE: begin
          if (in_take) state_r <= fplc_pkg::S_DECODE;
        end
        fplc_pkg::S_DECODE: begin
          state_r <= dec_state;
          wcnt_r  <= '0;
          if (dec_state == fplc_pkg::S_WRITE) ptr_r <= off_sum[AW-1:0] - AW'(CHUNK_BYTES);
          if (dec_state == fplc_pkg::S_CRC) begin
            ptr_r     <= '0;
            crc_iss_r <= 1'b1;
          end
        end
        fplc_pkg::S_WRITE: begin
          ptr_r  <= ptr_r + 1'b1;
          wcnt_r <= wcnt_r + 1'b1;
          if (wcnt_r == CNT_LAST) state_r <= fplc_pkg::S_FIN;
        end
        fplc_pkg::S_CRC: begin
          if (rd_en) begin
            ptr_r <= ptr_r + 1'b1;
            if (ptr_r == PTR_LAST) crc_iss_r <= 1'b0;
          end
          if (rd_vld_r && rd_last_r) state_r <= fplc_pkg::S_FIN;
        end
        fplc_pkg::S_FIN: begin
          // hold the result until the output register is free
          if (out_free) state_r <= fplc_pkg::S_IDLE;
        end
        default: begin
          state_r <= fplc_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_ch.func;
      len_r  <= in_ch.packet_len;
      off_r  <= in_ch.chunk_offset;
      data_r <= in_ch.chunk_data;
      addr_r <= in_ch.target_address;
      exp_r  <= in_ch.claimed_crc;
    end

    unique case (state_r)
      fplc_pkg::S_DECODE: begin
        res_status_r <= dec_status;
        res_start_r  <= dec_start;
        res_crc_r    <= 16'h0000;
        res_prog_r   <= 1'b0;
        res_paddr_r  <= 32'h0000_0000;
        crc_r        <= fplc_pkg::CRC_INIT;
      end
      fplc_pkg::S_WRITE: begin
        data_r <= data_r >> 8;
      end
      fplc_pkg::S_CRC: begin
        if (rd_vld_r) crc_r <= crc_upd;
        if (rd_vld_r && rd_last_r) begin
          res_crc_r <= crc_upd;
          if (crc_upd == exp_r) begin
            res_status_r <= fplc_pkg::ST_OK;
            if (func_r == fplc_pkg::FN_PROG) begin
              res_prog_r  <= 1'b1;
              res_paddr_r <= addr_r;
            end
          end else begin
            res_status_r <= fplc_pkg::ST_CRC_BAD;
          end
        end
      end
      fplc_pkg::S_FIN: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_crc_r    <= res_crc_r;
          out_prog_r   <= res_prog_r;
          out_paddr_r  <= res_paddr_r;
          out_start_r  <= res_start_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: tb/tb_flash_page_loader_crc_check_top.sv
`timescale 1ns / 1ps

module tb_flash_page_loader_crc_check_top;

  localparam int PAGE_BYTES  = 256;
  localparam int CHUNK_BYTES = 8;

  localparam logic [2:0] FN_FLASH_CRC = 3'd6;
  localparam logic [2:0] FN_SPARE     = 3'd7;
  localparam logic [6:0] LEN_WRITE    = 7'(2 + CHUNK_BYTES);

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  len;
    logic [7:0]  offset;
    logic [63:0] data;
    logic [31:0] addr;
    logic [15:0] crc;
  } command_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] crc;
    logic        prog;
    logic [31:0] paddr;
    logic        start;
  } outcome_t;

  typedef struct {
    command_t cmd;
    bit       good_crc;
    bit       typed;
    outcome_t outcome;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  fplc_in_if  in_ch ();
  fplc_out_if out_ch ();

  flash_page_loader_crc_check_top #(
    .PAGE_BYTES (PAGE_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the block: page buffer and address limits
  logic [7:0]  page_image [PAGE_BYTES];
  logic [31:0] low_limit;
  logic [31:0] high_limit;

  outcome_t  pending_results [$];
  plan_row_t plan [$];
  outcome_t  oldest;
  int        mismatches = 0;
  int        items_done = 0;
  int        burst_left = 0;
  bit        steady     = 1'b0;

  function automatic logic [15:0] page_crc16();
    logic [15:0] acc;
    acc = fplc_pkg::CRC_INIT;
    for (int i = 0; i < PAGE_BYTES; i++) begin
      acc ^= {8'h00, page_image[i]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ fplc_pkg::CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // work out one command's outcome and apply its effect on the buffer
  function automatic outcome_t apply_command(input command_t c);
    outcome_t r;
    r = '0;
    if (c.len == 7'd0) begin
      r.status = fplc_pkg::ST_HELLO;
    end else begin
      case (c.func)
        fplc_pkg::FN_NOP: r.status = fplc_pkg::ST_STAGE0;
        fplc_pkg::FN_WRITE: begin
          if (c.len != LEN_WRITE) begin
            r.status = fplc_pkg::ST_WRONG_SIZE;
          end else if (int'(c.offset) + CHUNK_BYTES > PAGE_BYTES) begin
            r.status = fplc_pkg::ST_OOB;
          end else begin
            for (int i = 0; i < CHUNK_BYTES; i++) page_image[int'(c.offset) + i] = c.data[8*i +: 8];
            r.status = fplc_pkg::ST_OK;
          end
        end
        fplc_pkg::FN_CHECK: begin
          if (c.len != fplc_pkg::LEN_CHECK) begin
            r.status = fplc_pkg::ST_WRONG_SIZE;
          end else begin
            r.crc    = page_crc16();
            r.status = (r.crc == c.crc) ? fplc_pkg::ST_OK : fplc_pkg::ST_CRC_BAD;
          end
        end
        fplc_pkg::FN_PROG: begin
          if (c.len != fplc_pkg::LEN_PROG) begin
            r.status = fplc_pkg::ST_WRONG_SIZE;
          end else if (c.addr < low_limit) begin
            r.status = fplc_pkg::ST_TOO_LOW;
          end else if (c.addr >= high_limit) begin
            r.status = fplc_pkg::ST_TOO_HIGH;
          end else if (c.addr % PAGE_BYTES != 0) begin
            r.status = fplc_pkg::ST_UNALIGNED;
          end else begin
            r.crc = page_crc16();
            if (r.crc == c.crc) begin
              r.status = fplc_pkg::ST_OK;
              r.prog   = 1'b1;
              r.paddr  = c.addr;
            end else begin
              r.status = fplc_pkg::ST_CRC_BAD;
            end
          end
        end
        fplc_pkg::FN_JUMP: begin
          r.status = fplc_pkg::ST_OK;
          r.start  = 1'b1;
        end
        fplc_pkg::FN_STAGE0: r.status = fplc_pkg::ST_OK;
        default: r.status = fplc_pkg::ST_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.func   = 3'($urandom_range(0, 7));
    c.len    = 7'($urandom_range(0, 127));
    c.offset = 8'($urandom);
    c.data   = {32'($urandom), 32'($urandom)};
    c.addr   = 32'($urandom);
    c.crc    = 16'($urandom);
    return c;
  endfunction

  function automatic logic [31:0] pick_address();
    logic [32:0] first_pg;
    logic [32:0] last_pg;
    first_pg = ({1'b0, low_limit} + 33'd255) >> 8;
    last_pg  = {1'b0, high_limit - 32'd1} >> 8;
    case ($urandom_range(0, 9))
      0: return low_limit - 32'd1;
      1: return low_limit;
      2: return high_limit - 32'd1;
      3: return high_limit;
      4: return 32'($urandom);
      5: return 32'($urandom) & 32'hFFFF_FF00;
      default: begin
        if (high_limit != 32'd0 && first_pg <= last_pg)
          return 32'($urandom_range(32'(first_pg), 32'(last_pg))) << 8;
        return 32'($urandom) & 32'hFFFF_FF00;
      end
    endcase
  endfunction

  // enter and leave at a falling edge; valid stays high across a burst
  task automatic send_command(input command_t c, input bit typed, input outcome_t fixed);
    outcome_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.func           = c.func;
    in_ch.packet_len     = c.len;
    in_ch.chunk_offset   = c.offset;
    in_ch.chunk_data     = c.data;
    in_ch.target_address = c.addr;
    in_ch.claimed_crc    = c.crc;
    in_ch.valid          = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_command(c);
    pending_results.push_back(typed ? fixed : r);
    items_done++;
    @(negedge clk);
  endtask

  task automatic write_limits(input logic [31:0] low_v, input logic [31:0] high_v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = fplc_pkg::REG_LOW;
    cfg_wdata = low_v;
    @(negedge clk);
    cfg_index = fplc_pkg::REG_HIGH;
    cfg_wdata = high_v;
    @(negedge clk);
    cfg_we     = 1'b0;
    low_limit  = low_v;
    high_limit = high_v;
  endtask

  task automatic drain(input int settle);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic add_row(input logic [2:0] func, input logic [6:0] len,
                         input logic [7:0] offset, input logic [63:0] data,
                         input logic [31:0] addr, input logic [15:0] crc,
                         input bit good_crc, input bit typed,
                         input logic [3:0] status, input logic start);
    plan_row_t row;
    row.cmd      = '{func, len, offset, data, addr, crc};
    row.good_crc = good_crc;
    row.typed    = typed;
    row.outcome  = '{status, 16'h0, 1'b0, 32'h0, start};
    plan.push_back(row);
  endtask

  // a page load: chunks, an optional check, then a program request
  task automatic page_session();
    command_t c;
    outcome_t none;
    none = '0;
    repeat ($urandom_range(1, 6)) begin
      c        = random_command();
      c.func   = fplc_pkg::FN_WRITE;
      c.len    = LEN_WRITE;
      case ($urandom_range(0, 9))
        0:       c.offset = 8'($urandom_range(248, 255));
        1, 2, 3: c.offset = 8'($urandom_range(0, 248));
        default: c.offset = 8'($urandom_range(0, 31) * 8);
      endcase
      send_command(c, 1'b0, none);
    end
    if ($urandom_range(0, 2) != 0) begin
      c      = random_command();
      c.func = fplc_pkg::FN_CHECK;
      c.len  = fplc_pkg::LEN_CHECK;
      if ($urandom_range(0, 4) != 0) c.crc = page_crc16();
      send_command(c, 1'b0, none);
    end
    c      = random_command();
    c.func = fplc_pkg::FN_PROG;
    c.len  = fplc_pkg::LEN_PROG;
    c.addr = pick_address();
    if ($urandom_range(0, 4) != 0) c.crc = page_crc16();
    send_command(c, 1'b0, none);
  endtask

  task automatic noise_command();
    command_t c;
    outcome_t none;
    none = '0;
    c    = random_command();
    if ($urandom_range(0, 1) == 0) begin
      case (c.func)
        fplc_pkg::FN_WRITE: c.len = LEN_WRITE;
        fplc_pkg::FN_CHECK: c.len = fplc_pkg::LEN_CHECK;
        fplc_pkg::FN_PROG:  c.len = fplc_pkg::LEN_PROG;
        default:            c.len = 7'($urandom_range(0, 2));
      endcase
    end
    send_command(c, 1'b0, none);
  endtask

  // receiver: ready follows a stall mask that is swapped now and then
  initial begin
    logic [15:0] stall_mask;
    int          pat_left;
    int          pat_pos;
    stall_mask   = '0;
    pat_left     = 0;
    pat_pos      = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pat_left == 0) begin
        pat_left = $urandom_range(32, 400);
        case ($urandom_range(0, 3))
          0:       stall_mask = '0;
          1:       stall_mask = 16'($urandom);
          2:       stall_mask = 16'($urandom) | 16'($urandom);
          default: stall_mask = 16'hFFFE;
        endcase
      end else begin
        pat_left--;
      end
      pat_pos      = (pat_pos + 1) % 16;
      out_ch.ready = !stall_mask[pat_pos];
    end
  end

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none outstanding, expected nothing got status %0d",
                 $time, out_ch.status);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", 32'(out_ch.status), 32'(oldest.status));
        check_field("computed_crc", 32'(out_ch.computed_crc), 32'(oldest.crc));
        check_field("program_request", 32'(out_ch.program_request), 32'(oldest.prog));
        check_field("program_address", out_ch.program_address, oldest.paddr);
        check_field("start_application", 32'(out_ch.start_application), 32'(oldest.start));
      end
    end
  end

  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    command_t c;
    int       goal;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = fplc_pkg::REG_LOW;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = fplc_pkg::FN_NOP;
    in_ch.packet_len     = '0;
    in_ch.chunk_offset   = '0;
    in_ch.chunk_data     = '0;
    in_ch.target_address = '0;
    in_ch.claimed_crc    = '0;
    foreach (page_image[i]) page_image[i] = 8'h00;
    low_limit  = fplc_pkg::LOW_RESET;
    high_limit = fplc_pkg::HIGH_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_limits(fplc_pkg::LOW_RESET, fplc_pkg::HIGH_RESET);

    add_row(fplc_pkg::FN_PROG, 7'd0, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_HELLO, 1'b0);
    add_row(fplc_pkg::FN_WRITE, 7'd0, 8'hFF, '1, '1, '1, 1'b0, 1'b1,
            fplc_pkg::ST_HELLO, 1'b0);
    add_row(fplc_pkg::FN_NOP, 7'd1, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_STAGE0, 1'b0);
    add_row(FN_FLASH_CRC, 7'd1, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_UNKNOWN, 1'b0);
    add_row(FN_SPARE, 7'd127, '1, '1, '1, '1, 1'b0, 1'b1, fplc_pkg::ST_UNKNOWN, 1'b0);
    add_row(fplc_pkg::FN_JUMP, 7'd1, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_OK, 1'b1);
    add_row(fplc_pkg::FN_STAGE0, 7'd127, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_WRITE, LEN_WRITE - 7'd1, 8'h00, '1, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_WRONG_SIZE, 1'b0);
    add_row(fplc_pkg::FN_WRITE, LEN_WRITE, 8'd249, '1, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_OOB, 1'b0);
    add_row(fplc_pkg::FN_WRITE, LEN_WRITE, 8'd255, '1, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_OOB, 1'b0);
    add_row(fplc_pkg::FN_CHECK, fplc_pkg::LEN_CHECK, 8'h00, 64'h0, 32'h0, 16'h0, 1'b1, 1'b0,
            fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_WRITE, LEN_WRITE, 8'd0, '1, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_WRITE, LEN_WRITE, 8'd248, 64'h0123_4567_89AB_CDEF, 32'h0, 16'h0,
            1'b0, 1'b1, fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_CHECK, fplc_pkg::LEN_CHECK + 7'd1, 8'h00, 64'h0, 32'h0, 16'h0,
            1'b0, 1'b1, fplc_pkg::ST_WRONG_SIZE, 1'b0);
    add_row(fplc_pkg::FN_CHECK, fplc_pkg::LEN_CHECK, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b0,
            fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_CHECK, fplc_pkg::LEN_CHECK, 8'h00, 64'h0, 32'h0, 16'h0, 1'b1, 1'b0,
            fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG - 7'd1, 8'h00, 64'h0, fplc_pkg::LOW_RESET,
            16'h0, 1'b0, 1'b1, fplc_pkg::ST_WRONG_SIZE, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_TOO_LOW, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, fplc_pkg::LOW_RESET - 32'd1,
            16'h0, 1'b0, 1'b1, fplc_pkg::ST_TOO_LOW, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, fplc_pkg::HIGH_RESET,
            16'h0, 1'b0, 1'b1, fplc_pkg::ST_TOO_HIGH, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, '1, 16'h0, 1'b0, 1'b1,
            fplc_pkg::ST_TOO_HIGH, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, fplc_pkg::LOW_RESET + 32'd1,
            16'h0, 1'b0, 1'b1, fplc_pkg::ST_UNALIGNED, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, fplc_pkg::HIGH_RESET - 32'd1,
            16'h0, 1'b0, 1'b1, fplc_pkg::ST_UNALIGNED, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0, fplc_pkg::LOW_RESET, '1,
            1'b0, 1'b0, fplc_pkg::ST_OK, 1'b0);
    add_row(fplc_pkg::FN_PROG, fplc_pkg::LEN_PROG, 8'h00, 64'h0,
            fplc_pkg::HIGH_RESET - 32'd256, 16'h0, 1'b1, 1'b0, fplc_pkg::ST_OK, 1'b0);

    foreach (plan[i]) begin
      c = plan[i].cmd;
      if (plan[i].good_crc) c.crc = page_crc16();
      send_command(c, plan[i].typed, plan[i].outcome);
    end

    goal = items_done;
    for (int phase = 0; phase < 5; phase++) begin
      drain(8);
      case (phase)
        0: write_limits('0, '1);
        1: begin
          c.addr = 32'($urandom_range(0, 32'h0004_0000));
          write_limits(c.addr, c.addr + 32'($urandom_range(0, 32'h0004_0000)));
        end
        2: write_limits('1, '0);
        3: write_limits(32'($urandom), 32'($urandom));
        default: write_limits(fplc_pkg::LOW_RESET, fplc_pkg::HIGH_RESET);
      endcase
      goal += 350;
      while (items_done < goal) begin
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 7) page_session();
        else noise_command();
      end
    end

    drain(300);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
